/* src/ubes_pkg.sv */
`timescale 1ns / 1ps
// Package for the unigram byte entropy scorer.
// Holds the item mode codes and the state types. It depends on nothing.
package ubes_pkg;

  typedef enum logic [1:0] {
    MODE_LEARN  = 2'd0,
    MODE_LOAD   = 2'd1,
    MODE_SCORE  = 2'd2,
    MODE_FINISH = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_LOGT,
    ST_LOGF,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    LG_IDLE,
    LG_NORM,
    LG_SQR
  } lg_state_t;

  localparam int unsigned LEN_BITS   = 32;
  localparam int unsigned ACC_BITS   = 48;
  localparam int unsigned SCORE_BITS = 17;
  localparam int unsigned Q_BITS     = 16;

endpackage

/* src/ubes_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the scorer's input and result items.
// They use nothing beyond plain logic types.
interface ubes_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  symbol;
  logic [31:0] load_count;

  modport source (output valid, mode, symbol, load_count, input ready);
  modport sink (input valid, mode, symbol, load_count, output ready);
endinterface

interface ubes_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] score_value;
  logic [47:0] bits_total;
  logic        empty_corpus;

  modport source (output valid, score_value, bits_total, empty_corpus, input ready);
  modport sink (input valid, score_value, bits_total, empty_corpus, output ready);
endinterface

/* src/ubes_log2.sv */
`timescale 1ns / 1ps
// Iterative fixed-point log2 unit: a one-bit-per-cycle normalizer and a shared squarer.
// Depends on ubes_pkg.
module ubes_log2 import ubes_pkg::*; #(
  parameter int unsigned COUNT_BITS = 32,
  parameter int unsigned FRAC_BITS  = 16,
  localparam int unsigned EW = $clog2(COUNT_BITS),
  localparam int unsigned LW = EW + FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [COUNT_BITS-1:0] x,
  output logic                  done,
  output logic [LW-1:0]         result
);

  localparam int unsigned CW = $clog2(FRAC_BITS);

  lg_state_t st, st_next;
  logic [COUNT_BITS-1:0]    norm;
  logic [EW-1:0]            e;
  logic [31:0]              m;
  logic [FRAC_BITS-1:0]     frac;
  logic [CW-1:0]            cnt;
  logic [63:0]              prod;
  logic [COUNT_BITS+31:0]   wide;
  logic                     last;

  assign prod   = m * m;
  assign wide   = {norm, 32'd0};
  assign last   = (cnt == CW'(FRAC_BITS - 1));
  assign result = {e, frac};

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= LG_IDLE;
      done <= 1'b0;
    end else begin
      st   <= st_next;
      done <= (st == LG_SQR) && last;
    end
  end

  always_comb begin
    st_next = st;
    case (st)
      LG_IDLE: if (start) st_next = LG_NORM;
      LG_NORM: if (norm[COUNT_BITS-1]) st_next = LG_SQR;
      LG_SQR:  if (last) st_next = LG_IDLE;
      default: st_next = LG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (st)
      LG_IDLE: begin
        if (start) begin
          norm <= x;
          e    <= EW'(COUNT_BITS - 1);
        end
      end
      LG_NORM: begin
        if (norm[COUNT_BITS-1]) begin
          m   <= wide[COUNT_BITS+31 -: 32];
          cnt <= '0;
        end else begin
          norm <= norm << 1;
          e    <= e - 1'b1;
        end
      end
      LG_SQR: begin
        m    <= prod[63] ? prod[63:32] : prod[62:31];
        frac <= {frac[FRAC_BITS-2:0], prod[63]};
        cnt  <= cnt + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

/* src/unigram_byte_entropy_scorer_top.sv */
`timescale 1ns / 1ps
// Top level of the unigram byte entropy scorer: histogram memory, sequencer, divider.
// Depends on ubes_pkg, ubes_if and ubes_log2.
//
// Items arrive on the sample channel and a finish item produces one item on the
// result channel; both use valid/ready. Learn and load items read the histogram
// entry and then write it back. A score item with an empty corpus ends after the
// read; otherwise it needs two log2 evaluations, which a single log2 unit runs
// one after the other, one squaring per cycle. A finish item runs the restoring
// divider that forms one quotient bit per cycle, or skips it when the score is
// forced to zero.
// Input ready is high only while the sequencer is idle.
// Reset clears the corpus total, the text accumulators and the per-entry valid
// bits of the histogram, so every entry reads as zero until written.
// A finished result sits in an output register; a new item is taken while it
// waits, and only a second finish stalls until the receiver has taken it.
module unigram_byte_entropy_scorer_top import ubes_pkg::*; #(
  parameter int unsigned COUNT_BITS = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input logic          clk,
  input logic          rst,
  ubes_in_if.sink      sample,
  ubes_out_if.source   result
);

  localparam int unsigned EW = $clog2(COUNT_BITS);
  localparam int unsigned LW = EW + FRAC_BITS;
  localparam int unsigned DW = LEN_BITS + 3 + FRAC_BITS;
  localparam logic [47:0] CMAX = (48'd1 << COUNT_BITS) - 48'd1;

  state_t state, state_next;
  mode_t  mode_q;
  logic [7:0]            sym_q;
  logic [31:0]           cnt_q;
  logic [COUNT_BITS-1:0] hist [256];
  logic [255:0]          vld;
  logic [COUNT_BITS-1:0] rd_q;
  logic                  vld_rd;
  logic [COUNT_BITS-1:0] corpus;
  logic [LEN_BITS-1:0]   len;
  logic [ACC_BITS-1:0]   acc;
  logic                  empty_q;
  logic [COUNT_BITS-1:0] f_q;
  logic [LW-1:0]         lt_q;
  logic [DW-1:0]         d_q;
  logic [DW:0]           rem;
  logic [Q_BITS-1:0]     q;
  logic [3:0]            dcnt;
  logic                  zero_q;
  logic                  ov;
  logic [SCORE_BITS-1:0] score_o;
  logic [ACC_BITS-1:0]   bits_o;
  logic                  empty_o;

  logic [COUNT_BITS-1:0] ent, ent_inc, cnt_sat, corpus_add, corpus_new;
  logic [COUNT_BITS:0]   sum_e, sum_c;
  logic [LEN_BITS:0]     sum_l;
  logic [ACC_BITS:0]     sum_a;
  logic [LW-1:0]         add;
  logic [DW-1:0]         d_new;
  logic [DW:0]           r2;
  logic                  lg_start, lg_done;
  logic [COUNT_BITS-1:0] lg_x;
  logic [LW-1:0]         lg_res;
  logic                  accept, out_load, div_zero;

  assign accept   = sample.valid && sample.ready;
  assign sample.ready = (state == ST_IDLE);
  assign out_load = (state == ST_OUT) && (!ov || result.ready);

  assign ent     = vld_rd ? rd_q : '0;
  assign sum_e   = {1'b0, ent} + {{COUNT_BITS{1'b0}}, 1'b1};
  assign ent_inc = sum_e[COUNT_BITS] ? '1 : sum_e[COUNT_BITS-1:0];
  assign cnt_sat = (48'(cnt_q) > CMAX) ? '1 : COUNT_BITS'(cnt_q);
  assign corpus_add = (mode_q == MODE_LOAD) ? cnt_sat : COUNT_BITS'(1);
  assign sum_c   = {1'b0, corpus} + {1'b0, corpus_add};
  assign corpus_new = sum_c[COUNT_BITS] ? '1 : sum_c[COUNT_BITS-1:0];
  assign sum_l   = {1'b0, len} + 33'd1;
  assign add     = (lt_q > lg_res) ? (lt_q - lg_res) : '0;
  assign sum_a   = {1'b0, acc} + (ACC_BITS + 1)'(add);
  assign d_new   = {len, 3'b000, {FRAC_BITS{1'b0}}};
  assign div_zero = (len == '0) || empty_q || (DW'(acc) >= d_new);
  assign r2      = rem << 1;

  assign lg_start = ((state == ST_RD) && (mode_q == MODE_SCORE) && (corpus != '0))
                 || ((state == ST_LOGT) && lg_done);
  assign lg_x     = (state == ST_RD) ? corpus : f_q;

  ubes_log2 #(
    .COUNT_BITS(COUNT_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_log2 (
    .clk   (clk),
    .rst   (rst),
    .start (lg_start),
    .x     (lg_x),
    .done  (lg_done),
    .result(lg_res)
  );

  always_ff @(posedge clk) begin
    if ((state == ST_RD) && ((mode_q == MODE_LEARN) || (mode_q == MODE_LOAD))) begin
      hist[sym_q] <= (mode_q == MODE_LOAD) ? cnt_sat : ent_inc;
    end
    rd_q <= hist[sample.symbol];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_RD;
      ST_RD: begin
        case (mode_q)
          MODE_SCORE:  state_next = (corpus != '0) ? ST_LOGT : ST_IDLE;
          MODE_FINISH: state_next = div_zero ? ST_OUT : ST_DIV;
          default:     state_next = ST_IDLE;
        endcase
      end
      ST_LOGT: if (lg_done) state_next = ST_LOGF;
      ST_LOGF: if (lg_done) state_next = ST_IDLE;
      ST_DIV:  if (dcnt == 4'd15) state_next = ST_OUT;
      ST_OUT:  if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      corpus  <= '0;
      len     <= '0;
      acc     <= '0;
      empty_q <= 1'b0;
      ov      <= 1'b0;
    end else begin
      if (accept) begin
        mode_q <= mode_t'(sample.mode);
        sym_q  <= sample.symbol;
        cnt_q  <= sample.load_count;
        vld_rd <= vld[sample.symbol];
      end
      if (out_load) begin
        ov <= 1'b1;
      end else if (ov && result.ready) begin
        ov <= 1'b0;
      end
      case (state)
        ST_RD: begin
          case (mode_q)
            MODE_LEARN, MODE_LOAD: begin
              vld[sym_q] <= 1'b1;
              corpus     <= corpus_new;
            end
            MODE_SCORE: begin
              len <= sum_l[LEN_BITS] ? '1 : sum_l[LEN_BITS-1:0];
              if (corpus == '0) begin
                empty_q <= 1'b1;
              end
              f_q <= (ent == '0) ? COUNT_BITS'(1) : ent;
            end
            default: begin
              zero_q <= div_zero;
              d_q    <= d_new;
              rem    <= (DW + 1)'(acc);
              q      <= '0;
              dcnt   <= '0;
            end
          endcase
        end
        ST_LOGT: begin
          if (lg_done) begin
            lt_q <= lg_res;
          end
        end
        ST_LOGF: begin
          if (lg_done) begin
            acc <= sum_a[ACC_BITS] ? '1 : sum_a[ACC_BITS-1:0];
          end
        end
        ST_DIV: begin
          if (r2 >= {1'b0, d_q}) begin
            rem <= r2 - {1'b0, d_q};
            q   <= {q[Q_BITS-2:0], 1'b1};
          end else begin
            rem <= r2;
            q   <= {q[Q_BITS-2:0], 1'b0};
          end
          dcnt <= dcnt + 1'b1;
        end
        ST_OUT: begin
          if (out_load) begin
            score_o <= zero_q ? '0 : (17'd65536 - {1'b0, q});
            bits_o  <= acc;
            empty_o <= empty_q;
            len     <= '0;
            acc     <= '0;
            empty_q <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign result.valid        = ov;
  assign result.score_value  = score_o;
  assign result.bits_total   = bits_o;
  assign result.empty_corpus = empty_o;

  a_logf_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOGF && lg_done) |=> (state == ST_IDLE))
    else $error("score item did not finish after second log2");

  a_out_clears: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (result.valid && len == '0 && acc == '0 && !empty_q))
    else $error("finish did not present a result and clear the text state");

  a_rise_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> ($past(state) == ST_OUT))
    else $error("result raised outside the output step");

endmodule
